// ===== design/gbtc_pkg.sv =====
// Shared types, constants and command/status structs of the guard-band clipper.
`default_nettype none

package gbtc_pkg;

  localparam int ATTR_W       = 32;
  localparam int NUM_ATTR     = 9;
  localparam int VTX_W        = NUM_ATTR * ATTR_W;
  localparam int T_BITS       = 24;
  localparam int FAN_VERT_CAP = 3 + 5;
  localparam int EXT_W        = 17;
  localparam int NEAR_W_W     = 31;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_IDX_W    = 2;

  // Extent (17 bits unsigned) times w (32 bits signed) fits in 49 signed bits.
  localparam int GP_W    = EXT_W + ATTR_W;
  localparam int MUL_A_W = ATTR_W + 1;
  localparam int MUL_B_W = T_BITS + 2;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Attribute positions inside a vertex.
  localparam int AT_X = 0;
  localparam int AT_Y = 1;
  localparam int AT_W = 3;

  // Outcode bit positions.
  localparam int OC_W    = 9;
  localparam int OC_NEAR = 0;
  localparam int OC_VXP  = 1;
  localparam int OC_VXN  = 2;
  localparam int OC_VYP  = 3;
  localparam int OC_VYN  = 4;
  localparam int OC_GXP  = 5;
  localparam int OC_GXN  = 6;
  localparam int OC_GYP  = 7;
  localparam int OC_GYN  = 8;
  localparam logic [OC_W-1:0] OC_REJECT_MASK = 9'h01F;

  // Clip planes in processing order.
  localparam int NUM_PLANES = 5;
  localparam logic [2:0] PL_NEAR = 3'd0;
  localparam logic [2:0] PL_GXP  = 3'd1;
  localparam logic [2:0] PL_GXN  = 3'd2;
  localparam logic [2:0] PL_GYP  = 3'd3;
  localparam logic [2:0] PL_GYN  = 3'd4;
  localparam logic [2:0] PL_DONE = 3'd5;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_VIS_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIS_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_W = 2'd3;
  localparam logic [EXT_W-1:0]    RST_VIS_X  = 17'd10752;
  localparam logic [EXT_W-1:0]    RST_VIS_Y  = 17'd7526;
  localparam logic [EXT_W-1:0]    RST_GUARD  = 17'd62259;
  localparam logic [NEAR_W_W-1:0] RST_NEAR_W = 31'd65536;

  typedef logic [NUM_ATTR-1:0][ATTR_W-1:0] vertex_t;

  typedef enum logic [2:0] {
    MS_VX, MS_VY, MS_GIN, MS_GA, MS_GB, MS_LERP
  } mul_sel_t;

  typedef enum logic [1:0] {
    OS_NONE, OS_VX, OS_VY, OS_G
  } oc_step_t;

  typedef enum logic [1:0] {
    WS_IN, WS_A, WS_LERP
  } wr_src_t;

  typedef struct packed {
    logic       cap_in;
    logic       mul_en;
    mul_sel_t   mul_sel;
    logic [3:0] attr;
    oc_step_t   oc_step;
    logic       oc_fold;
    logic       oc_first;
    logic       rd_en;
    logic       da_load;
    logic       db_load;
    logic [2:0] plane;
    logic       div_start;
    logic       lerp_store;
    logic       wr_en;
    wr_src_t    wr_src;
    logic       out_load;
    logic       out_tri_end;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic                  reject;
    logic [NUM_PLANES-1:0] need;
    logic                  ina;
    logic                  inb;
    logic                  div_done;
    logic                  out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== design/gbtc_div.sv =====
// Restoring fraction divider: quot = floor(num * 2^24 / den), saturating at 1.0.
`default_nettype none

module gbtc_div import gbtc_pkg::*; #(
  parameter int W = 51
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [W-1:0]   num,
  input  wire logic [W-1:0]   den,
  output logic                done,
  output logic [T_BITS:0]     quot
);

  localparam int CNT_W = $clog2(T_BITS + 1);

  logic [W-1:0]     rem;
  logic [W-1:0]     dsor;
  logic [W:0]       rem2;
  logic             ge;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  assign rem2 = {rem, 1'b0};
  assign ge   = rem2 >= {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (num >= den) begin
          quot <= (T_BITS+1)'(1) << T_BITS;
          done <= 1'b1;
        end else begin
          rem  <= num;
          dsor <= den;
          quot <= '0;
          cnt  <= CNT_W'(T_BITS);
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem  <= W'(ge ? rem2 - {1'b0, dsor} : rem2);
        quot <= {quot[T_BITS-1:0], ge};
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/gbtc_dp.sv =====
// Datapath: vertex buffers, shared multiplier, outcodes, distances, lerp, output register.
`default_nettype none

module gbtc_dp import gbtc_pkg::*; #(
  parameter int MAX_POLY_VERTS = 8,
  parameter int FRAC_BITS = 16,
  localparam int AW = $clog2(2 * MAX_POLY_VERTS)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  input  wire logic [AW-1:0]         rd_a_addr,
  input  wire logic [AW-1:0]         rd_b_addr,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire vertex_t               in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  out_ready,
  output status_t                    st,
  output logic                       out_valid,
  output vertex_t                    out_data,
  output logic                       out_tri_end,
  output logic                       out_last
);

  localparam int DEPTH = 2 * MAX_POLY_VERTS;
  localparam int XS_W  = ATTR_W + FRAC_BITS;
  localparam int DW    = ((XS_W > GP_W) ? XS_W : GP_W) + 1;
  localparam int DIV_W = DW + 1;
  localparam logic signed [MUL_P_W-1:0] RND = MUL_P_W'(1) <<< (T_BITS - 1);

  vertex_t vmem [DEPTH];
  vertex_t ra, rb, vin, lerp_v, wr_data;

  logic [EXT_W-1:0]    vis_x, vis_y, guard;
  logic [NEAR_W_W-1:0] near_w;

  logic [OC_W-1:0] vcode, oc_and, oc_or;
  logic            near_in;

  logic signed [MUL_A_W-1:0] ma;
  logic signed [MUL_B_W-1:0] mb;
  logic signed [MUL_P_W-1:0] prod, rsum;
  logic signed [DW-1:0]      pext, da, db, xs_in, ys_in;
  logic [DIV_W-1:0]          abs_a, abs_b, dnum, dden;
  logic [T_BITS:0]           quot;
  logic                      div_done;

  function automatic logic signed [DW-1:0] scale(input logic [ATTR_W-1:0] v);
    return DW'($signed(v)) <<< FRAC_BITS;
  endfunction

  function automatic logic signed [DW-1:0] plane_dist(input logic [2:0] p,
                                                      input vertex_t v,
                                                      input logic signed [DW-1:0] g,
                                                      input logic [NEAR_W_W-1:0] nw);
    logic signed [DW-1:0] r;
    case (p)
      PL_NEAR: r = DW'($signed(v[AT_W])) - DW'($signed({1'b0, nw}));
      PL_GXP:  r = g - scale(v[AT_X]);
      PL_GXN:  r = g + scale(v[AT_X]);
      PL_GYP:  r = g - scale(v[AT_Y]);
      default: r = g + scale(v[AT_Y]);
    endcase
    return r;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vis_x  <= RST_VIS_X;
      vis_y  <= RST_VIS_Y;
      guard  <= RST_GUARD;
      near_w <= RST_NEAR_W;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VIS_X:  vis_x  <= cfg_data[EXT_W-1:0];
        REG_VIS_Y:  vis_y  <= cfg_data[EXT_W-1:0];
        REG_GUARD:  guard  <= cfg_data[EXT_W-1:0];
        REG_NEAR_W: near_w <= cfg_data[NEAR_W_W-1:0];
        default: ;
      endcase
    end
  end

  // Vertex buffer: the low half holds the gathered triangle; clip stages alternate halves.
  always_comb begin
    case (cmd.wr_src)
      WS_IN:   wr_data = in_data;
      WS_A:    wr_data = ra;
      default: wr_data = lerp_v;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) vmem[wr_addr] <= wr_data;
    if (cmd.rd_en) begin
      ra <= vmem[rd_a_addr];
      rb <= vmem[rd_b_addr];
    end
  end

  // Shared multiplier with a registered product.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_sel)
      MS_VX:  begin ma = MUL_A_W'($signed(vin[AT_W])); mb = MUL_B_W'(vis_x); end
      MS_VY:  begin ma = MUL_A_W'($signed(vin[AT_W])); mb = MUL_B_W'(vis_y); end
      MS_GIN: begin ma = MUL_A_W'($signed(vin[AT_W])); mb = MUL_B_W'(guard); end
      MS_GA:  begin ma = MUL_A_W'($signed(ra[AT_W]));  mb = MUL_B_W'(guard); end
      MS_GB:  begin ma = MUL_A_W'($signed(rb[AT_W]));  mb = MUL_B_W'(guard); end
      MS_LERP: begin
        ma = MUL_A_W'($signed(rb[cmd.attr])) - MUL_A_W'($signed(ra[cmd.attr]));
        mb = MUL_B_W'(quot);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= ma * mb;
  end

  assign pext    = DW'($signed(prod[GP_W-1:0]));
  assign xs_in   = scale(vin[AT_X]);
  assign ys_in   = scale(vin[AT_Y]);
  assign near_in = $signed(in_data[AT_W]) < $signed({1'b0, near_w});

  // Outcodes of the incoming vertex, folded into the triangle's AND and OR.
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      vin   <= in_data;
      vcode <= OC_W'(near_in);
    end
    case (cmd.oc_step)
      OS_VX: begin
        vcode[OC_VXP] <= xs_in > pext;
        vcode[OC_VXN] <= xs_in < -pext;
      end
      OS_VY: begin
        vcode[OC_VYP] <= ys_in > pext;
        vcode[OC_VYN] <= ys_in < -pext;
      end
      OS_G: begin
        vcode[OC_GXP] <= xs_in > pext;
        vcode[OC_GXN] <= xs_in < -pext;
        vcode[OC_GYP] <= ys_in > pext;
        vcode[OC_GYN] <= ys_in < -pext;
      end
      default: ;
    endcase
    if (cmd.oc_fold) begin
      oc_and <= cmd.oc_first ? vcode : (oc_and & vcode);
      oc_or  <= cmd.oc_first ? vcode : (oc_or | vcode);
    end
  end

  // Plane distances of the current edge.
  always_ff @(posedge clk) begin
    if (cmd.da_load) da <= plane_dist(cmd.plane, ra, pext, near_w);
    if (cmd.db_load) db <= plane_dist(cmd.plane, rb, pext, near_w);
  end

  assign abs_a = da[DW-1] ? -DIV_W'(da) : DIV_W'(da);
  assign abs_b = db[DW-1] ? -DIV_W'(db) : DIV_W'(db);
  assign dnum  = abs_a;
  assign dden  = abs_a + abs_b;

  gbtc_div #(.W(DIV_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (dnum),
    .den   (dden),
    .done  (div_done),
    .quot  (quot)
  );

  // Round to nearest, ties up: floor((d * t + 2^23) / 2^24).
  assign rsum = prod + RND;

  always_ff @(posedge clk) begin
    if (cmd.lerp_store) lerp_v[cmd.attr] <= ra[cmd.attr] + rsum[T_BITS +: ATTR_W];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data    <= ra;
      out_tri_end <= cmd.out_tri_end;
      out_last    <= cmd.out_last;
    end
  end

  always_comb begin
    st.reject   = |(oc_and & OC_REJECT_MASK);
    st.need     = {oc_or[OC_GYN], oc_or[OC_GYP], oc_or[OC_GXN], oc_or[OC_GXP], oc_or[OC_NEAR]};
    st.ina      = !da[DW-1];
    st.inb      = !db[DW-1];
    st.div_done = div_done;
    st.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// ===== design/gbtc_ctrl.sv =====
// Controller: gathers triangles, sequences the clip stages and the fan emission.
`default_nettype none

module gbtc_ctrl import gbtc_pkg::*; #(
  parameter int MAX_POLY_VERTS = 8,
  localparam int AW = $clog2(2 * MAX_POLY_VERTS)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire status_t       st,
  output cmd_t               cmd,
  output logic [AW-1:0]      rd_a_addr,
  output logic [AW-1:0]      rd_b_addr,
  output logic [AW-1:0]      wr_addr
);

  localparam int CW = $clog2(MAX_POLY_VERTS + 1);

  typedef enum logic [4:0] {
    S_IN, S_OC1, S_OC2, S_OC3, S_OC4, S_OC5, S_DECIDE, S_PLANE,
    S_EREAD, S_EGA, S_EGB, S_EDB, S_EKEEP, S_ECROSS, S_EDIV,
    S_LMUL, S_LADD, S_LWR, S_ENEXT, S_FAN0, S_FRD, S_FOUT
  } state_t;

  state_t        state;
  logic [1:0]    slot;
  logic [2:0]    plane;
  logic [CW-1:0] idx, count, oc, fan_n, fi;
  logic [1:0]    fj;
  logic [3:0]    k;
  logic          pong;

  logic [CW-1:0] idx_next, fsel, fan_cap;
  logic          edge_wrap, oc_room, last_tri;

  function automatic logic [AW-1:0] baddr(input logic sel, input logic [CW-1:0] i);
    return sel ? AW'(MAX_POLY_VERTS) + AW'(i) : AW'(i);
  endfunction

  assign edge_wrap = (idx + CW'(1)) == count;
  assign idx_next  = edge_wrap ? '0 : idx + CW'(1);
  assign oc_room   = oc < CW'(MAX_POLY_VERTS);
  assign fsel      = (fj == 2'd0) ? '0 : fi + CW'(fj) - CW'(1);
  assign fan_cap   = (count > CW'(FAN_VERT_CAP)) ? CW'(FAN_VERT_CAP) : count;
  assign last_tri  = (fi + CW'(2)) == fan_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
      slot  <= '0;
      plane <= '0;
      idx   <= '0;
      count <= '0;
      oc    <= '0;
      fan_n <= '0;
      fi    <= '0;
      fj    <= '0;
      k     <= '0;
      pong  <= 1'b0;
    end else begin
      case (state)
        S_IN:  if (in_valid) state <= S_OC1;
        S_OC1: state <= S_OC2;
        S_OC2: state <= S_OC3;
        S_OC3: state <= S_OC4;
        S_OC4: state <= S_OC5;
        S_OC5: begin
          if (slot == 2'd2) begin
            slot  <= '0;
            state <= S_DECIDE;
          end else begin
            slot  <= slot + 2'd1;
            state <= S_IN;
          end
        end
        S_DECIDE: begin
          if (st.reject) begin
            state <= S_IN;
          end else begin
            count <= CW'(3);
            pong  <= 1'b0;
            plane <= PL_NEAR;
            state <= S_PLANE;
          end
        end
        S_PLANE: begin
          if (plane == PL_DONE || count == '0) begin
            state <= S_FAN0;
          end else if (st.need[plane]) begin
            idx   <= '0;
            oc    <= '0;
            state <= S_EREAD;
          end else begin
            plane <= plane + 3'd1;
          end
        end
        S_EREAD: state <= S_EGA;
        S_EGA:   state <= S_EGB;
        S_EGB:   state <= S_EDB;
        S_EDB:   state <= S_EKEEP;
        S_EKEEP: begin
          if (st.ina && oc_room) oc <= oc + CW'(1);
          state <= S_ECROSS;
        end
        S_ECROSS: state <= ((st.ina != st.inb) && oc_room) ? S_EDIV : S_ENEXT;
        S_EDIV: begin
          if (st.div_done) begin
            k     <= '0;
            state <= S_LMUL;
          end
        end
        S_LMUL: state <= S_LADD;
        S_LADD: begin
          if (k == 4'(NUM_ATTR - 1)) begin
            state <= S_LWR;
          end else begin
            k     <= k + 4'd1;
            state <= S_LMUL;
          end
        end
        S_LWR: begin
          oc    <= oc + CW'(1);
          state <= S_ENEXT;
        end
        S_ENEXT: begin
          if (edge_wrap) begin
            count <= oc;
            pong  <= !pong;
            plane <= plane + 3'd1;
            state <= S_PLANE;
          end else begin
            idx   <= idx_next;
            state <= S_EREAD;
          end
        end
        S_FAN0: begin
          if (fan_cap < CW'(3)) begin
            state <= S_IN;
          end else begin
            fan_n <= fan_cap;
            fi    <= CW'(1);
            fj    <= '0;
            state <= S_FRD;
          end
        end
        S_FRD: state <= S_FOUT;
        S_FOUT: begin
          if (st.out_free) begin
            if (fj == 2'd2) begin
              if (last_tri) begin
                state <= S_IN;
              end else begin
                fi    <= fi + CW'(1);
                fj    <= '0;
                state <= S_FRD;
              end
            end else begin
              fj    <= fj + 2'd1;
              state <= S_FRD;
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.plane = plane;
    cmd.attr  = k;
    in_ready  = 1'b0;
    rd_a_addr = baddr(pong, idx);
    rd_b_addr = baddr(pong, idx_next);
    wr_addr   = baddr(!pong, oc);
    case (state)
      S_IN: begin
        in_ready   = 1'b1;
        cmd.cap_in = in_valid;
        cmd.wr_en  = in_valid;
        cmd.wr_src = WS_IN;
        wr_addr    = AW'(slot);
      end
      S_OC1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_VX;
      end
      S_OC2: begin
        cmd.oc_step = OS_VX;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_VY;
      end
      S_OC3: begin
        cmd.oc_step = OS_VY;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_GIN;
      end
      S_OC4: cmd.oc_step = OS_G;
      S_OC5: begin
        cmd.oc_fold  = 1'b1;
        cmd.oc_first = slot == 2'd0;
      end
      S_EREAD: cmd.rd_en = 1'b1;
      S_EGA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_GA;
      end
      S_EGB: begin
        cmd.da_load = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_GB;
      end
      S_EDB: cmd.db_load = 1'b1;
      S_EKEEP: begin
        cmd.wr_en  = st.ina && oc_room;
        cmd.wr_src = WS_A;
      end
      S_ECROSS: cmd.div_start = (st.ina != st.inb) && oc_room;
      S_LMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_LERP;
      end
      S_LADD: cmd.lerp_store = 1'b1;
      S_LWR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WS_LERP;
      end
      S_FRD: begin
        cmd.rd_en = 1'b1;
        rd_a_addr = baddr(pong, fsel);
      end
      S_FOUT: begin
        cmd.out_load    = st.out_free;
        cmd.out_tri_end = fj == 2'd2;
        cmd.out_last    = (fj == 2'd2) && last_tri;
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POLY_VERTS)) else $error("polygon count beyond buffer depth");

  a_oc_bound: assert property (@(posedge clk) disable iff (rst)
    oc <= CW'(MAX_POLY_VERTS)) else $error("clip stage output beyond buffer depth");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free) else $error("output register overwritten");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot != 2'd3) else $error("vertex slot out of range");

endmodule

`default_nettype wire

// ===== design/guard_band_triangle_clipper_unit.sv =====
// Guard-band triangle clipper: gathers vertices, culls, clips and emits triangle fans.
//
// Input stream (s_axis_*): one clip-space vertex per item, every three items form a
// triangle. After accepting a vertex the block computes its outcodes (three products
// on the shared multiplier) and accepts the next vertex only when that is done.
// After the third vertex a rejected triangle is dropped in the decision state.
// Otherwise the block checks each clip plane in turn and runs each active clip stage
// over every polygon edge; a crossing edge also waits for the 24-step divider (which
// skips the steps when the fraction is exactly one), then forms each attribute on the
// multiplier and stores the new vertex. The result is sent as a fan of up to 6
// triangles (18 items); each item is read from the buffer and then loaded into the
// output register once it is free. A triangle needing no clipping goes through the
// decision and the plane checks before its three items.
// Output stream (m_axis_*): one result vertex per item from an output register;
// tlast marks the last vertex sent for the input triangle and tuser the third vertex
// of each triangle. When the receiver stalls the block holds the item and waits.
// Configuration writes (cfg_*) are always taken; issue them only while idle.
// Reset is synchronous: it restores the register defaults and starts a new triangle.
`default_nettype none

module guard_band_triangle_clipper_unit import gbtc_pkg::*; #(
  parameter int MAX_POLY_VERTS = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // pos_x, pos_y, pos_z, pos_w, red, green, blue, tex_s, tex_t
  input  wire logic [VTX_W-1:0]      s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // out_x, out_y, out_z, out_w, out_red, out_green, out_blue, out_s, out_t
  output logic [VTX_W-1:0]           m_axis_tdata,
  // triangle_end
  output logic                       m_axis_tuser,
  output logic                       m_axis_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(2 * MAX_POLY_VERTS);

  cmd_t          cmd;
  status_t       st;
  logic [AW-1:0] rd_a_addr, rd_b_addr, wr_addr;
  vertex_t       out_vtx;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = out_vtx;

  gbtc_ctrl #(.MAX_POLY_VERTS(MAX_POLY_VERTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .st        (st),
    .cmd       (cmd),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .wr_addr   (wr_addr)
  );

  gbtc_dp #(.MAX_POLY_VERTS(MAX_POLY_VERTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rd_a_addr   (rd_a_addr),
    .rd_b_addr   (rd_b_addr),
    .wr_addr     (wr_addr),
    .in_data     (s_axis_tdata),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_ready   (m_axis_tready),
    .st          (st),
    .out_valid   (m_axis_tvalid),
    .out_data    (out_vtx),
    .out_tri_end (m_axis_tuser),
    .out_last    (m_axis_tlast)
  );

endmodule

`default_nettype wire
